/* rtl/bdlp_pkg.sv */
// Shared types and constants for the button debouncer with long-press detection.
// Used by the channel interfaces, the per-button lane, the event merge stage and the top level.
// No dependencies.
package bdlp_pkg;

    // Sizes
    localparam int NUM_BUTTONS = 3;   // buttons polled side by side
    localparam int FIELD_W     = 3;   // width of the level and event mask fields
    localparam int TIME_W      = 32;  // millisecond timestamp width
    localparam int CFG_W       = 16;  // widest configuration register
    localparam int CFG_IDX_W   = 2;   // configuration register index width

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL  = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST   = 16'd40;
    localparam logic [CFG_W-1:0] LONG_PRESS_MS_RST = 16'd500;
    localparam logic             ACTIVE_LEVEL_RST  = 1'b0;

    // Live configuration, fanned out to every lane
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic             active_level;
    } t_cfg;

    // Events one lane raises for the poll in flight
    typedef struct packed {
        logic down;
        logic up;
        logic lng;
    } t_lane_evt;

endpackage

/* rtl/bdlp_poll_if.sv */
// Poll channel: valid/ready handshake carrying a timestamp and the raw pin levels.
// Depends on bdlp_pkg.
interface bdlp_poll_if
    import bdlp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  now_ms;
    logic [FIELD_W-1:0] raw_levels;

    modport source (output valid, output now_ms, output raw_levels, input ready);
    modport sink   (input valid, input now_ms, input raw_levels, output ready);
endinterface

/* rtl/bdlp_evt_if.sv */
// Event channel: valid/ready handshake carrying the down, up and long event masks.
// Depends on bdlp_pkg.
interface bdlp_evt_if
    import bdlp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] down_mask;
    logic [FIELD_W-1:0] up_mask;
    logic [FIELD_W-1:0] long_mask;

    modport source (output valid, output down_mask, output up_mask, output long_mask,
                    input ready);
    modport sink   (input valid, input down_mask, input up_mask, input long_mask,
                    output ready);
endinterface

/* rtl/bdlp_lane.sv */
// One button lane: four-phase debounce / press / long-press machine with its timestamp.
// Depends on bdlp_pkg.
module bdlp_lane
    import bdlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,     // poll transfer this cycle
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_level,
    input  t_cfg              i_cfg,
    output t_lane_evt         o_evt
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_PRESSED,
        PH_LONG
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_mark, n_mark;
    logic              w_active;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_db_done;
    logic              w_long_done;

    // Wrapping elapsed time since the mark, compared unsigned
    assign w_active    = (i_level == i_cfg.active_level);
    assign w_elapsed   = i_now_ms - r_mark;
    assign w_db_done   = (w_elapsed >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_ms});
    assign w_long_done = (w_elapsed >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms});

    // Next phase and events for the poll at the inputs
    always_comb begin
        n_phase    = r_phase;
        n_mark     = r_mark;
        o_evt      = '0;
        case (r_phase)
            PH_IDLE: begin
                if (w_active) begin
                    n_mark  = i_now_ms;
                    n_phase = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (w_db_done) begin
                    if (w_active) begin
                        n_mark     = i_now_ms;
                        n_phase    = PH_PRESSED;
                        o_evt.down = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_PRESSED: begin
                if (w_active) begin
                    if (w_long_done) begin
                        o_evt.lng = 1'b1;
                        n_phase   = PH_LONG;
                    end
                end else begin
                    o_evt.up = 1'b1;
                    n_phase  = PH_IDLE;
                end
            end
            PH_LONG: begin
                if (!w_active) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Phase and mark advance only on a poll transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mark  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_mark  <= n_mark;
        end
    end

endmodule

/* rtl/bdlp_merge.sv */
// Merge stage: gathers lane events into masks and holds them in an output register
// backed by a skid register. Depends on bdlp_pkg.
module bdlp_merge
    import bdlp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,                  // poll transfer this cycle
    input  t_lane_evt  i_evt [NUM_BUTTONS],
    output logic       o_ready,                 // room for another poll
    bdlp_evt_if.source o_evt
);

    logic [FIELD_W-1:0] w_down, w_up, w_long;
    logic               r_out_v, r_skid_v;
    logic [FIELD_W-1:0] r_out_down, r_out_up, r_out_long;
    logic [FIELD_W-1:0] r_skid_down, r_skid_up, r_skid_long;
    logic               w_out_free;

    // Lane events into masks; buttons past the field width are dropped
    always_comb begin
        w_down = '0;
        w_up   = '0;
        w_long = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (i < FIELD_W) begin
                w_down[i] = i_evt[i].down;
                w_up[i]   = i_evt[i].up;
                w_long[i] = i_evt[i].lng;
            end
        end
    end

    assign o_ready    = !r_skid_v;
    assign w_out_free = !r_out_v || o_evt.ready;

    // Output register with skid: skid drains first to keep order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_step;
            end
        end else if (i_step) begin
            r_skid_v <= 1'b1;
        end

        if (w_out_free) begin
            if (r_skid_v) begin
                r_out_down <= r_skid_down;
                r_out_up   <= r_skid_up;
                r_out_long <= r_skid_long;
            end else begin
                r_out_down <= w_down;
                r_out_up   <= w_up;
                r_out_long <= w_long;
            end
        end else if (i_step) begin
            r_skid_down <= w_down;
            r_skid_up   <= w_up;
            r_skid_long <= w_long;
        end
    end

    assign o_evt.valid     = r_out_v;
    assign o_evt.down_mask = r_out_down;
    assign o_evt.up_mask   = r_out_up;
    assign o_evt.long_mask = r_out_long;

endmodule

/* rtl/button_debounce_long_press.sv */
// Button debouncer with long-press detection, top level.
// Depends on bdlp_pkg, bdlp_poll_if, bdlp_evt_if, bdlp_lane and bdlp_merge.
//
// Each poll transfer carries a millisecond timestamp and one raw pin level per
// button; every transfer yields exactly one event transfer holding the down, up
// and long masks for that poll. All buttons are updated in parallel lanes in the
// cycle the poll is taken, so one poll is accepted per clock when not stalled,
// and its masks are registered in the output register or, while the output is
// stalled, in the skid register behind it; polls are held off only once both
// are full. Elapsed times use wrapping 32-bit subtraction. Configuration
// (debounce time, long-press time, active level) is written through the write
// port; the user must write it only while no poll is in flight (not enforced).
module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bdlp_poll_if.sink            i_poll,
    bdlp_evt_if.source           o_evt
);

    t_cfg      r_cfg;
    t_lane_evt w_evt [NUM_BUTTONS];
    logic      w_ready;
    logic      w_step;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_MS_RST;
            r_cfg.long_press_ms <= LONG_PRESS_MS_RST;
            r_cfg.active_level  <= ACTIVE_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE_MS:   r_cfg.debounce_ms   <= i_cfg_data;
                CFG_LONG_PRESS_MS: r_cfg.long_press_ms <= i_cfg_data;
                CFG_ACTIVE_LEVEL:  r_cfg.active_level  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign i_poll.ready = w_ready;
    assign w_step       = i_poll.valid && w_ready;

    // One lane per button; buttons past the field width see level 0
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic w_level;
        if (g < FIELD_W) begin : g_pin
            assign w_level = i_poll.raw_levels[g];
        end else begin : g_nopin
            assign w_level = 1'b0;
        end
        bdlp_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (w_step),
            .i_now_ms (i_poll.now_ms),
            .i_level  (w_level),
            .i_cfg    (r_cfg),
            .o_evt    (w_evt[g])
        );
    end

    bdlp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_evt   (w_evt),
        .o_ready (w_ready),
        .o_evt   (o_evt)
    );

endmodule

/* test/bdlp_event_checker.sv */
// Scoreboard for the button debouncer: tracks register writes, predicts the event masks of
// every poll transfer and compares them with the event transfers, oldest first.
// Depends on bdlp_pkg, bdlp_poll_if and bdlp_evt_if.
module bdlp_event_checker
    import bdlp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bdlp_poll_if                 i_poll,
    bdlp_evt_if                  i_evt,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_event_bits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 30;

    typedef enum logic [1:0] {
        BTN_IDLE,
        BTN_SETTLING,
        BTN_HELD,
        BTN_LONG_HELD
    } t_btn_phase;

    typedef struct packed {
        logic [FIELD_W-1:0] down;
        logic [FIELD_W-1:0] up;
        logic [FIELD_W-1:0] lng;
    } t_evt_masks;

    // Shadow of the block's state and registers
    t_btn_phase        btn_phase [NUM_BUTTONS];
    logic [TIME_W-1:0] btn_mark  [NUM_BUTTONS];
    logic [CFG_W-1:0]  cfg_debounce;
    logic [CFG_W-1:0]  cfg_long;
    logic              cfg_active;

    t_evt_masks expected_masks_q [$];
    int         n_fail    = 0;
    int         n_checked = 0;
    int         n_events  = 0;

    // One poll: advance every button and collect its events
    function automatic t_evt_masks step_buttons(input logic [TIME_W-1:0] now,
                                                input logic [FIELD_W-1:0] raw);
        t_evt_masks        ev;
        logic              level;
        logic              pressed;
        logic [TIME_W-1:0] held_for;
        ev = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            level    = (b < FIELD_W) ? raw[b] : 1'b0;
            pressed  = (level == cfg_active);
            held_for = now - btn_mark[b];  // wraps modulo 2^32
            case (btn_phase[b])
                BTN_IDLE: begin
                    if (pressed) begin
                        btn_mark[b]  = now;
                        btn_phase[b] = BTN_SETTLING;
                    end
                end
                BTN_SETTLING: begin
                    if (held_for >= cfg_debounce) begin
                        if (pressed) begin
                            btn_mark[b]  = now;
                            btn_phase[b] = BTN_HELD;
                            if (b < FIELD_W) ev.down[b] = 1'b1;
                        end else begin
                            btn_phase[b] = BTN_IDLE;
                        end
                    end
                end
                BTN_HELD: begin
                    if (!pressed) begin
                        btn_phase[b] = BTN_IDLE;
                        if (b < FIELD_W) ev.up[b] = 1'b1;
                    end else if (held_for >= cfg_long) begin
                        btn_phase[b] = BTN_LONG_HELD;
                        if (b < FIELD_W) ev.lng[b] = 1'b1;
                    end
                end
                default: begin
                    // release after a long press is silent
                    if (!pressed) btn_phase[b] = BTN_IDLE;
                end
            endcase
        end
        return ev;
    endfunction

    function automatic void report_field(input string field, input logic [FIELD_W-1:0] want,
                                         input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            if (n_fail < REPORT_LIMIT)
                $display("%0t: result %0d %s expected %b actual %b",
                         $time, n_checked, field, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_evt_masks want;
        if (!i_rst_n) begin
            cfg_debounce = DEBOUNCE_MS_RST;
            cfg_long     = LONG_PRESS_MS_RST;
            cfg_active   = ACTIVE_LEVEL_RST;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                btn_phase[b] = BTN_IDLE;
                btn_mark[b]  = '0;
            end
            expected_masks_q.delete();
        end else begin
            // register writes; unknown indexes leave everything alone
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE_MS:   cfg_debounce = i_cfg_data;
                    CFG_LONG_PRESS_MS: cfg_long     = i_cfg_data;
                    CFG_ACTIVE_LEVEL:  cfg_active   = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_poll.valid && i_poll.ready)
                expected_masks_q.push_back(step_buttons(i_poll.now_ms, i_poll.raw_levels));

            // compare each event transfer with the oldest prediction
            if (i_evt.valid && i_evt.ready) begin
                if (expected_masks_q.size() == 0) begin
                    if (n_fail < REPORT_LIMIT)
                        $display("%0t: unexpected event transfer, expected none, actual %b %b %b",
                                 $time, i_evt.down_mask, i_evt.up_mask, i_evt.long_mask);
                    n_fail++;
                end else begin
                    want = expected_masks_q.pop_front();
                    report_field("down_mask", want.down, i_evt.down_mask);
                    report_field("up_mask",   want.up,   i_evt.up_mask);
                    report_field("long_mask", want.lng,  i_evt.long_mask);
                    n_events += $countones({want.down, want.up, want.lng});
                    n_checked++;
                end
            end
        end
    end

    assign o_fail_count = n_fail;
    assign o_pending    = expected_masks_q.size();
    assign o_checked    = n_checked;
    assign o_event_bits = n_events;

endmodule

/* test/testbench.sv */
// Top of the button debouncer regression: clock, reset, register writes, poll stimulus and
// output back-pressure. Checking is done by bdlp_event_checker.
// Depends on bdlp_pkg, bdlp_poll_if, bdlp_evt_if, bdlp_event_checker and the block itself.
module testbench
    import bdlp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;   // no register behind it
    localparam int NUM_SETTINGS      = 8;
    localparam int POLLS_PER_SETTING = 230;
    localparam int HOLD_SETTING      = 3;    // setting in which the sink holds off long
    localparam int SINK_HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT       = 3000;
    localparam int SETTLE_CYCLES     = 16;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    bdlp_poll_if poll_bus ();
    bdlp_evt_if  evt_bus ();

    int fail_count;
    int pending;
    int checked;
    int event_bits;

    button_debounce_long_press u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_poll     (poll_bus),
        .o_evt      (evt_bus)
    );

    bdlp_event_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_poll       (poll_bus),
        .i_evt        (evt_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_event_bits (event_bits)
    );

    // Stimulus state: the intended finger position of each button and how long it stays
    logic [TIME_W-1:0]  clock_ms;
    logic [FIELD_W-1:0] finger_down;
    logic [TIME_W-1:0]  hold_start [FIELD_W];
    logic [TIME_W-1:0]  hold_len   [FIELD_W];
    logic [CFG_W-1:0]   cur_debounce;
    logic [CFG_W-1:0]   cur_long;
    logic               cur_active;
    bit                 gaps_on;
    bit                 sink_hold_req;
    int                 polls_sent;
    int                 quiet_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short idles, now and then a long one
    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // How long the finger stays in its new position, measured against the live times
    function automatic logic [TIME_W-1:0] pick_hold(input bit pressing);
        int unsigned deb;
        int unsigned lng;
        deb = 32'(cur_debounce);
        lng = 32'(cur_long);
        case ($urandom_range(0, pressing ? 3 : 1))
            0:       return $urandom_range(0, deb);                // chatter
            1:       return deb + $urandom_range(0, deb + 4);
            2:       return deb + $urandom_range(0, lng);          // short press
            default: return deb + lng + $urandom_range(0, lng + 50);
        endcase
    endfunction

    task automatic send_poll(input logic [TIME_W-1:0] t, input logic [FIELD_W-1:0] raw);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? gap_length() : 0;
        if (gap > 0) begin
            poll_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_bus.valid      <= 1'b1;
        poll_bus.now_ms     <= t;
        poll_bus.raw_levels <= raw;
        @(posedge clk);
        while (!poll_bus.ready) @(posedge clk);
        polls_sent++;
    endtask

    // Stop offering and wait for every outstanding event transfer
    task automatic wait_drained();
        poll_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_MS:   cur_debounce = data;
            CFG_LONG_PRESS_MS: cur_long     = data;
            CFG_ACTIVE_LEVEL:  cur_active   = data[0];
            default: ;
        endcase
    endtask

    // All three registers plus the unused index, in a rotating order
    task automatic apply_setting(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                                 input logic act);
        int first;
        first = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
            case ((first + k) % 4)
                0:       write_reg(CFG_DEBOUNCE_MS, deb);
                1:       write_reg(CFG_LONG_PRESS_MS, lng);
                2:       write_reg(CFG_ACTIVE_LEVEL,
                                   {(CFG_W-1)'($urandom_range(0, 16'h7FFF)), act});
                default: write_reg(CFG_SPARE_IDX, CFG_W'($urandom));
            endcase
        end
    endtask

    // Advance time, move fingers when their hold runs out, add some contact chatter
    task automatic random_poll();
        logic [FIELD_W-1:0] raw;
        int unsigned        step_max;
        int                 roll;
        int                 flip;
        step_max = (cur_debounce + cur_long) / 8 + 3;
        roll     = $urandom_range(0, 99);
        if (roll < 2)
            clock_ms = $urandom;    // jump anywhere, often backwards
        else if (roll >= 6)
            clock_ms = clock_ms + $urandom_range(1, step_max);
        for (int b = 0; b < FIELD_W; b++) begin
            if (clock_ms - hold_start[b] >= hold_len[b]) begin
                finger_down[b] = ~finger_down[b];
                hold_start[b]  = clock_ms;
                hold_len[b]    = pick_hold(finger_down[b]);
            end
            raw[b] = finger_down[b] ? cur_active : ~cur_active;
        end
        if ($urandom_range(0, 99) < 5) begin
            flip      = $urandom_range(0, FIELD_W - 1);
            raw[flip] = ~raw[flip];
        end
        send_poll(clock_ms, raw);
    endtask

    // Output side: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        evt_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                evt_bus.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
            end else if (stall_left > 0) begin
                evt_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                evt_bus.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 4) == 0) stall_left = gap_length();
            end
        end
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge clk) begin
        if (!rst_n || (poll_bus.valid && poll_bus.ready) || (evt_bus.valid && evt_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending);
            $display("button_debounce_long_press regression: fail");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] lng;
        logic             act;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        poll_bus.valid      <= 1'b0;
        poll_bus.now_ms     <= '0;
        poll_bus.raw_levels <= '0;
        cur_debounce  = DEBOUNCE_MS_RST;
        cur_long      = LONG_PRESS_MS_RST;
        cur_active    = ACTIVE_LEVEL_RST;
        finger_down   = '0;
        gaps_on       = 1'b1;
        sink_hold_req = 1'b0;
        polls_sent    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings (active low): press, release, long press, silent release
        send_poll(32'd0,   3'b111);
        send_poll(32'd10,  3'b000);
        send_poll(32'd50,  3'b000);     // debounce exactly met: all down
        send_poll(32'd100, 3'b100);     // button 2 released from a short press
        send_poll(32'd550, 3'b100);     // long press exactly met
        send_poll(32'd560, 3'b111);     // released from long press, no event
        send_poll(32'd600, 3'b110);
        send_poll(32'd620, 3'b111);     // still settling
        send_poll(32'd700, 3'b111);     // bounce dropped back to idle
        // debounce across the timestamp wrap, then a timestamp that runs backwards
        send_poll(32'hFFFF_FFF0, 3'b101);
        send_poll(32'h0000_0018, 3'b101);
        send_poll(32'h0000_0010, 3'b101);
        send_poll(32'h0000_0010, 3'b111);
        send_poll(32'hFFFF_FFFF, 3'b111);
        send_poll(32'h0000_0000, 3'b000);
        send_poll(32'hFFFF_FFFF, 3'b111);
        wait_drained();

        // Directed, zero times and active high
        apply_setting(16'd0, 16'd0, 1'b1);
        send_poll(32'd5, 3'b111);
        send_poll(32'd5, 3'b111);       // zero debounce: down on the next poll
        send_poll(32'd5, 3'b111);       // zero long press: long on the next poll
        send_poll(32'd6, 3'b010);
        send_poll(32'd6, 3'b000);
        send_poll(32'd7, 3'b001);
        send_poll(32'd7, 3'b001);
        send_poll(32'd8, 3'b000);       // short release
        wait_drained();

        // Random part, one register setting per stretch
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            case (s)
                0: begin deb = DEBOUNCE_MS_RST; lng = LONG_PRESS_MS_RST; act = 1'b0; end
                1: begin deb = 16'd0;     lng = 16'd0;     act = 1'b1; end
                2: begin deb = 16'hFFFF;  lng = 16'hFFFF;  act = 1'b0; end
                4: begin deb = 16'd0;     lng = 16'hFFFF;  act = 1'b1; end
                5: begin deb = 16'hFFFF;  lng = 16'd0;     act = 1'b0; end
                6: begin deb = CFG_W'($urandom); lng = CFG_W'($urandom); act = 1'($urandom); end
                default: begin
                    deb = CFG_W'($urandom_range(1, 8));
                    lng = CFG_W'($urandom_range(1, 30));
                    act = 1'($urandom);
                end
            endcase
            apply_setting(deb, lng, act);
            clock_ms = s[0] ? (32'hFFFF_FFFF - $urandom_range(0, 4000)) : $urandom;
            for (int b = 0; b < FIELD_W; b++) begin
                hold_start[b] = clock_ms;
                hold_len[b]   = pick_hold(finger_down[b]);
            end
            gaps_on = (s != 1 && s != 6);   // two stretches run back to back
            for (int n = 0; n < POLLS_PER_SETTING; n++) begin
                if (s == HOLD_SETTING && n == 60) sink_hold_req = 1'b1;
                random_poll();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d polls over %0d register settings; %0d results, %0d event bits checked.",
                 polls_sent, NUM_SETTINGS + 2, checked, event_bits);
        $display("Included zero and full-scale times, both levels, wrapped and backward stamps.");
        if (fail_count == 0 && pending == 0)
            $display("button_debounce_long_press regression: pass");
        else
            $display("button_debounce_long_press regression: fail");
        $finish;
    end

endmodule
